// File: design/pcg32_bounded_random_generator_assert.svh
// ----------------------------------------------------------------------------
// pcg32 bounded random generator assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef PCG32_BOUNDED_RANDOM_GENERATOR_ASSERT_SVH
`define PCG32_BOUNDED_RANDOM_GENERATOR_ASSERT_SVH

// property checked on every rising edge outside reset
`define PCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// signal must hold its value in the cycle after the condition
`define PCG_HOLD(lbl, cond, sig, msg) \
    `PCG_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

// File: design/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

    // lcg multiplier 6364136223846793005
    localparam logic [63:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] SEED_RESET = 64'd42;
    localparam logic [63:0] STATE_RESET = 64'd0;
    localparam logic [63:0] INC_RESET  = 64'd1;

    // operation codes
    localparam logic [1:0] OP_RESEED  = 2'd0;
    localparam logic [1:0] OP_RAW     = 2'd1;
    localparam logic [1:0] OP_BOUNDED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_ADVANCE,
        ST_ADD_SEED,
        ST_MUL_DRAW,
        ST_CHECK,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    // operand pairs for the shared 32x32 multiplier
    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH,
        MUL_DRAW
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_DRAW,
        RES_BOUNDED
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     reseed_init;
        logic     add_seed;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     draw_load;
        logic     acc_load;
        logic     acc_add;
        logic     advance;
        logic     div_start;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       range_zero;
        logic       low_lt_range;
        logic       low_lt_thr;
        logic       div_last;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/pcg_rem.sv
// ----------------------------------------------------------------------------
// pcg_rem
// bit-serial remainder unit: (2^32 - divisor) mod divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_rem
    import pcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] divisor,
    output logic             last,
    output logic [31:0]      rem
);

    localparam int REM_W = 32;
    localparam int CNT_W = $clog2(REM_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] num_reg, num_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;

    assign last = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;

    always_comb
    begin
        trial     = {rem_reg, num_reg[REM_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            num_next  = '0 - divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // restoring step, partial remainder stays below the divisor
            rem_next = diff[REM_W] ? trial[REM_W-1:0] : diff[REM_W-1:0];
            num_next = {num_reg[REM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

// File: design/pcg_datapath.sv
// ----------------------------------------------------------------------------
// pcg_datapath
// generator state, shared multiplier, range logic and output register
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_datapath
    import pcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [63:0] cfg_data,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] range_low,
    input  wire logic [31:0] range_high,
    input  wire logic        out_stall,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic             out_valid,
    output logic [31:0]      random_value
);

    logic [63:0] seed_reg, seed_next;
    logic [63:0] state_reg, state_next;
    logic [63:0] inc_reg, inc_next;
    logic [1:0]  op_reg;
    logic [31:0] lo_reg;
    logic [31:0] range_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] draw_reg;
    logic [31:0] result_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] random_value_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [31:0] sum_hi;
    logic [31:0] bounded;
    logic [31:0] thr;
    logic        div_last;

    // xsh-rr output permutation of the old state
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] x;
        logic [31:0] mixed;
        logic [4:0]  rot;
        logic [63:0] dbl;
        x     = (old >> 18) ^ old;
        mixed = x[58:27];
        rot   = old[63:59];
        dbl   = {mixed, mixed} >> rot;
        return dbl[31:0];
    endfunction

    pcg_rem u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (range_reg),
        .last    (div_last),
        .rem     (thr)
    );

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LL:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[31:0];
            end
            MUL_HL:
            begin
                mul_a = state_reg[63:32];
                mul_b = LCG_MULT[31:0];
            end
            MUL_LH:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[63:32];
            end
            default:
            begin
                mul_a = draw_reg;
                mul_b = range_reg;
            end
        endcase
    end

    assign product = {32'd0, mul_a} * {32'd0, mul_b};
    assign sum_hi  = acc_reg[63:32] + prod_reg[31:0];
    assign bounded = lo_reg + prod_reg[63:32];

    always_comb
    begin
        seed_next  = cfg_write ? cfg_data : seed_reg;
        state_next = state_reg;
        inc_next   = inc_reg;
        if (cmd.reseed_init)
        begin
            state_next = STATE_RESET;
            inc_next   = {seed_reg[62:0], 1'b1};
        end
        else if (cmd.advance)
        begin
            state_next = {sum_hi, acc_reg[31:0]} + {inc_reg[63:1], 1'b1};
        end
        else if (cmd.add_seed)
        begin
            state_next = state_reg + seed_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            state_reg     <= STATE_RESET;
            inc_reg       <= INC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            state_reg     <= state_next;
            inc_reg       <= inc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            lo_reg    <= range_low;
            range_reg <= range_high - range_low + 32'd1;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= product;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_reg[63:32] <= sum_hi;
        end
        if (cmd.draw_load)
        begin
            draw_reg <= xsh_rr(state_reg);
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_DRAW:    result_reg <= draw_reg;
                RES_BOUNDED: result_reg <= bounded;
                default:     result_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            random_value_reg <= result_reg;
        end
    end

    assign status.op           = op_reg;
    assign status.range_zero   = (range_reg == '0);
    assign status.low_lt_range = (prod_reg[31:0] < range_reg);
    assign status.low_lt_thr   = (prod_reg[31:0] < thr);
    assign status.div_last     = div_last;
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign random_value = random_value_reg;

endmodule

`default_nettype wire

// File: design/pcg_ctrl.sv
// ----------------------------------------------------------------------------
// pcg_ctrl
// sequencer for reseed, generator step and bounded draw with rejection
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_ctrl
    import pcg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            in_stall
);

    state_t state_reg, state_next;
    logic   first_pass_reg, first_pass_next;
    logic   thr_valid_reg, thr_valid_next;

    // next state
    always_comb
    begin
        state_next      = state_reg;
        first_pass_next = first_pass_reg;
        thr_valid_next  = thr_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                thr_valid_next  = 1'b0;
                first_pass_next = 1'b1;
                unique case (status.op) inside
                    OP_RESEED, OP_RAW, OP_BOUNDED: state_next = ST_MUL_LL;
                    default:                       state_next = ST_EMIT;
                endcase
            end
            ST_MUL_LL: state_next = ST_MUL_HL;
            ST_MUL_HL: state_next = ST_MUL_LH;
            ST_MUL_LH: state_next = ST_ADVANCE;
            ST_ADVANCE:
            begin
                if (status.op == OP_RESEED && first_pass_reg)
                begin
                    state_next = ST_ADD_SEED;
                end
                else if (status.op == OP_BOUNDED && !status.range_zero)
                begin
                    state_next = ST_MUL_DRAW;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ADD_SEED:
            begin
                first_pass_next = 1'b0;
                state_next      = ST_MUL_LL;
            end
            ST_MUL_DRAW: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!status.low_lt_range)
                begin
                    state_next = ST_EMIT;
                end
                else if (!thr_valid_reg)
                begin
                    state_next = ST_DIV_RUN;
                end
                else if (status.low_lt_thr)
                begin
                    state_next = ST_MUL_LL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV_RUN:
            begin
                if (status.div_last)
                begin
                    thr_valid_next = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.mul_sel = MUL_LL;
        cmd.res_sel = RES_ZERO;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_DISPATCH:
            begin
                unique case (status.op) inside
                    OP_RESEED:
                    begin
                        cmd.reseed_init = 1'b1;
                    end
                    OP_RAW, OP_BOUNDED:
                    begin
                        cmd.reseed_init = 1'b0;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            ST_MUL_LL:
            begin
                cmd.mul_en    = 1'b1;
                cmd.draw_load = 1'b1;
            end
            ST_MUL_HL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_HL;
                cmd.acc_load = 1'b1;
            end
            ST_MUL_LH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LH;
                cmd.acc_add = 1'b1;
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                if (status.op == OP_RESEED && first_pass_reg)
                begin
                    cmd.res_load = 1'b0;
                end
                else if (status.op == OP_BOUNDED && !status.range_zero)
                begin
                    cmd.res_load = 1'b0;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = (status.op == OP_RESEED) ? RES_ZERO : RES_DRAW;
                end
            end
            ST_ADD_SEED:
            begin
                cmd.add_seed = 1'b1;
            end
            ST_MUL_DRAW:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DRAW;
            end
            ST_CHECK:
            begin
                if (!status.low_lt_range)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_BOUNDED;
                end
                else if (!thr_valid_reg)
                begin
                    cmd.div_start = 1'b1;
                end
                else if (!status.low_lt_thr)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_BOUNDED;
                end
            end
            ST_DIV_RUN:
            begin
                cmd.div_start = 1'b0;
            end
            ST_EMIT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_pass_reg <= 1'b0;
            thr_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_pass_reg <= first_pass_next;
            thr_valid_reg  <= thr_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/pcg32_bounded_random_generator.sv
// ----------------------------------------------------------------------------
// pcg32_bounded_random_generator
// pcg32 xsh-rr generator with reseed, raw draw and multiply-and-reject
// bounded draw into an inclusive, wrapping range
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   operation, range_low, range_high
// out       source     out_valid / out_stall random_value
// cfg       sink       cfg_write             cfg_data (seed)
//
// one item at a time; a generator step runs on the shared 32x32
// multiplier (three partial products of the 64-bit lcg multiply, then the add)
// raw draw: one step; reseed: step, seed add, step; bounded draw: a step,
// the draw-by-range multiply and a check, a new step per redraw, plus the
// serial remainder the first time a low product falls under the range
// reset gives state 0, increment 1, seed 42; no clearing pass
// a waiting result sits in the output register under out_stall while the next
// transfer on the input is already taken
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_bounded_random_generator
    import pcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // seed register write
    input  wire logic        cfg_write,
    input  wire logic [63:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] range_low,
    input  wire logic [31:0] range_high,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      random_value
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: steps the generator, decides on redraws
    pcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // datapath: lcg state, increment, seed, multiplier, remainder unit,
    // output register
    pcg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .random_value (random_value)
    );

endmodule

`default_nettype wire

// File: design/pcg_chk.sv
// ----------------------------------------------------------------------------
// pcg_chk
// port-level checker for the generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcg32_bounded_random_generator_assert.svh"

module pcg_chk
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] random_value
);

    logic [1:0] pending_reg, pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // transfers taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `PCG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
    `PCG_HOLD(a_out_stable, out_valid && out_stall, random_value, "result changed under stall")
    `PCG_ASSERT(a_no_phantom, (pending_reg == 2'd0) |-> !out_valid, "result without transfer")
    `PCG_ASSERT(a_one_in_work, (pending_reg == 2'd2) |-> in_stall, "second item taken in work")

endmodule

bind pcg32_bounded_random_generator pcg_chk u_chk (.*);

`default_nettype wire
